>>> sv/sci_pkg.sv
// shared types and constants of the segment / circle crossing pipeline
// no dependencies
package sci_pkg;

   localparam int FRAC_BITS = 16;

   // segments with |d|^2 * 2^-(2*FRAC_BITS) below 1e-8 count as degenerate
   localparam logic [65:0] DEGEN_LIMIT =
      66'(((64'd1 << (2 * FRAC_BITS)) - 64'd1) / 64'd100000000);

   localparam int SQRT_IN_W  = 128;
   localparam int SQRT_OUT_W = 64;

   localparam int DIV_NUM_W = 101;
   localparam int DIV_DEN_W = 67;
   localparam int DIV_QUO_W = 33;

   typedef struct packed {
      logic signed [31:0] sx;
      logic signed [31:0] sy;
      logic signed [32:0] dx;
      logic signed [32:0] dy;
   } seg_type;

   typedef struct packed {
      seg_type            seg;
      logic [65:0]        a;
      logic signed [66:0] h;
      logic               zero;
      logic               kill;
   } pre_type;

   typedef struct packed {
      seg_type    seg;
      logic [1:0] count;
   } post_type;

endpackage

>>> sv/sci_isqrt.sv
// pipelined floor square root, one result bit per stage
// depends on sci_pkg
module sci_isqrt (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic [sci_pkg::SQRT_IN_W-1:0]   in_value,
   output logic                            out_valid,
   output logic [sci_pkg::SQRT_OUT_W-1:0]  out_root
);
   import sci_pkg::*;

   logic [SQRT_IN_W:0]    rem_ff  [1:SQRT_OUT_W];
   logic [SQRT_OUT_W-1:0] root_ff [1:SQRT_OUT_W];
   logic                  vld_ff  [1:SQRT_OUT_W];

   for (genvar k = 0; k < SQRT_OUT_W; k++) begin : g_stage
      localparam int B = SQRT_OUT_W - 1 - k;
      logic [SQRT_IN_W:0]    rem_i;
      logic [SQRT_OUT_W-1:0] root_i;
      logic                  vld_i;
      logic [SQRT_IN_W:0]    trial;

      if (k == 0) begin : g_first
         assign rem_i  = {1'b0, in_value};
         assign root_i = '0;
         assign vld_i  = in_valid;
      end else begin : g_next
         assign rem_i  = rem_ff[k];
         assign root_i = root_ff[k];
         assign vld_i  = vld_ff[k];
      end

      assign trial = ((SQRT_IN_W+1)'(root_i) << (B + 1)) | ((SQRT_IN_W+1)'(1) << (2 * B));

      always_ff @(posedge clock) begin
         if (rem_i >= trial) begin
            rem_ff[k+1]  <= rem_i - trial;
            root_ff[k+1] <= root_i | (SQRT_OUT_W'(1) << B);
         end else begin
            rem_ff[k+1]  <= rem_i;
            root_ff[k+1] <= root_i;
         end
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else begin
            vld_ff[k+1] <= vld_i;
         end
      end
   end

   assign out_valid = vld_ff[SQRT_OUT_W];
   assign out_root  = root_ff[SQRT_OUT_W];

endmodule

>>> sv/sci_div.sv
// pipelined restoring divider, one quotient bit per stage
// depends on sci_pkg
module sci_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic [sci_pkg::DIV_NUM_W-1:0]  in_num,
   input  logic [sci_pkg::DIV_DEN_W-1:0]  in_den,
   output logic                           out_valid,
   output logic [sci_pkg::DIV_QUO_W-1:0]  out_quo
);
   import sci_pkg::*;

   logic [DIV_NUM_W-1:0] rem_ff [1:DIV_QUO_W];
   logic [DIV_DEN_W-1:0] den_ff [1:DIV_QUO_W];
   logic [DIV_QUO_W-1:0] quo_ff [1:DIV_QUO_W];
   logic                 vld_ff [1:DIV_QUO_W];

   for (genvar k = 0; k < DIV_QUO_W; k++) begin : g_stage
      localparam int B = DIV_QUO_W - 1 - k;
      logic [DIV_NUM_W-1:0] rem_i;
      logic [DIV_DEN_W-1:0] den_i;
      logic [DIV_QUO_W-1:0] quo_i;
      logic                 vld_i;
      logic [DIV_NUM_W-1:0] den_sh;

      if (k == 0) begin : g_first
         assign rem_i = in_num;
         assign den_i = in_den;
         assign quo_i = '0;
         assign vld_i = in_valid;
      end else begin : g_next
         assign rem_i = rem_ff[k];
         assign den_i = den_ff[k];
         assign quo_i = quo_ff[k];
         assign vld_i = vld_ff[k];
      end

      assign den_sh = DIV_NUM_W'(den_i) << B;

      always_ff @(posedge clock) begin
         den_ff[k+1] <= den_i;
         if (rem_i >= den_sh) begin
            rem_ff[k+1] <= rem_i - den_sh;
            quo_ff[k+1] <= quo_i | (DIV_QUO_W'(1) << B);
         end else begin
            rem_ff[k+1] <= rem_i;
            quo_ff[k+1] <= quo_i;
         end
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else begin
            vld_ff[k+1] <= vld_i;
         end
      end
   end

   assign out_valid = vld_ff[DIV_QUO_W];
   assign out_quo   = quo_ff[DIV_QUO_W];

endmodule

>>> sv/segment_circle_intersection_unit.sv
// top level of the segment / circle crossing pipeline
// depends on sci_pkg, sci_isqrt and sci_div
//
// Takes one segment and circle per cycle; busy is never raised. Each query gives one
// result strobe on rsp_valid once its start transfer has passed all stages: six stages
// form a, h and the discriminant a*r^2 - (d x p)^2, 64 stages of bit-serial square root,
// three stages select the roots and form n*|d|, 33 stages of division and one output stage.
module segment_circle_intersection_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_start_x,
   input  logic signed [31:0] req_start_y,
   input  logic signed [31:0] req_end_x,
   input  logic signed [31:0] req_end_y,
   input  logic signed [31:0] req_center_x,
   input  logic signed [31:0] req_center_y,
   input  logic [30:0]        req_circle_radius,
   output logic               rsp_valid,
   output logic [1:0]         rsp_hit_count,
   output logic signed [31:0] rsp_first_x,
   output logic signed [31:0] rsp_first_y,
   output logic signed [31:0] rsp_second_x,
   output logic signed [31:0] rsp_second_y
);
   import sci_pkg::*;

   assign busy = 1'b0;

   // stage 1: differences
   logic               s1_vld_ff;
   seg_type            s1_seg_ff;
   logic signed [32:0] s1_px_ff, s1_py_ff;
   logic [30:0]        s1_r_ff;
   seg_type            s1_seg_in;

   always_comb begin
      s1_seg_in.sx = req_start_x;
      s1_seg_in.sy = req_start_y;
      s1_seg_in.dx = {req_end_x[31], req_end_x} - {req_start_x[31], req_start_x};
      s1_seg_in.dy = {req_end_y[31], req_end_y} - {req_start_y[31], req_start_y};
   end

   always_ff @(posedge clock) begin
      s1_seg_ff <= s1_seg_in;
      s1_px_ff  <= {req_start_x[31], req_start_x} - {req_center_x[31], req_center_x};
      s1_py_ff  <= {req_start_y[31], req_start_y} - {req_center_y[31], req_center_y};
      s1_r_ff   <= req_circle_radius;
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= start & ~busy;
      end
   end

   // stage 2: products
   logic               s2_vld_ff;
   seg_type            s2_seg_ff;
   logic signed [65:0] s2_dxdx_ff, s2_dydy_ff, s2_dxpx_ff, s2_dypy_ff, s2_dxpy_ff, s2_dypx_ff;
   logic [61:0]        s2_r2_ff;

   always_ff @(posedge clock) begin
      s2_seg_ff  <= s1_seg_ff;
      s2_dxdx_ff <= s1_seg_ff.dx * s1_seg_ff.dx;
      s2_dydy_ff <= s1_seg_ff.dy * s1_seg_ff.dy;
      s2_dxpx_ff <= s1_seg_ff.dx * s1_px_ff;
      s2_dypy_ff <= s1_seg_ff.dy * s1_py_ff;
      s2_dxpy_ff <= s1_seg_ff.dx * s1_py_ff;
      s2_dypx_ff <= s1_seg_ff.dy * s1_px_ff;
      s2_r2_ff   <= 62'(s1_r_ff) * 62'(s1_r_ff);
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   // stage 3: a, h, cross
   logic               s3_vld_ff;
   seg_type            s3_seg_ff;
   logic [65:0]        s3_a_ff;
   logic signed [66:0] s3_h_ff, s3_cross_ff;
   logic [61:0]        s3_r2_ff;

   always_ff @(posedge clock) begin
      s3_seg_ff   <= s2_seg_ff;
      s3_a_ff     <= $unsigned(s2_dxdx_ff) + $unsigned(s2_dydy_ff);
      s3_h_ff     <= {s2_dxpx_ff[65], s2_dxpx_ff} + {s2_dypy_ff[65], s2_dypy_ff};
      s3_cross_ff <= {s2_dxpy_ff[65], s2_dxpy_ff} - {s2_dypx_ff[65], s2_dypx_ff};
      s3_r2_ff    <= s2_r2_ff;
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   // stage 4: partial products of cross^2 and a*r^2
   logic               s4_vld_ff;
   seg_type            s4_seg_ff;
   logic [65:0]        s4_a_ff;
   logic signed [66:0] s4_h_ff;
   logic [67:0]        s4_cc_hh_ff;
   logic [65:0]        s4_cc_hl_ff;
   logic [63:0]        s4_cc_ll_ff;
   logic [63:0]        s4_ar_hh_ff, s4_ar_ll_ff;
   logic [65:0]        s4_ar_hl_ff;
   logic [61:0]        s4_ar_lh_ff;
   logic [66:0]        s4_cneg_in;
   logic [65:0]        s4_cm_in;

   always_comb begin
      s4_cneg_in = -s3_cross_ff;
      s4_cm_in   = s3_cross_ff[66] ? s4_cneg_in[65:0] : s3_cross_ff[65:0];
   end

   always_ff @(posedge clock) begin
      s4_seg_ff   <= s3_seg_ff;
      s4_a_ff     <= s3_a_ff;
      s4_h_ff     <= s3_h_ff;
      s4_cc_hh_ff <= 68'(s4_cm_in[65:32]) * 68'(s4_cm_in[65:32]);
      s4_cc_hl_ff <= 66'(s4_cm_in[65:32]) * 66'(s4_cm_in[31:0]);
      s4_cc_ll_ff <= 64'(s4_cm_in[31:0]) * 64'(s4_cm_in[31:0]);
      s4_ar_hh_ff <= 64'(s3_a_ff[65:32]) * 64'(s3_r2_ff[61:32]);
      s4_ar_hl_ff <= 66'(s3_a_ff[65:32]) * 66'(s3_r2_ff[31:0]);
      s4_ar_lh_ff <= 62'(s3_a_ff[31:0]) * 62'(s3_r2_ff[61:32]);
      s4_ar_ll_ff <= 64'(s3_a_ff[31:0]) * 64'(s3_r2_ff[31:0]);
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else begin
         s4_vld_ff <= s3_vld_ff;
      end
   end

   // stage 5: full products cross^2 and a*r^2
   logic               s5_vld_ff;
   seg_type            s5_seg_ff;
   logic [65:0]        s5_a_ff;
   logic signed [66:0] s5_h_ff;
   logic [131:0]       s5_cr2_ff, s5_ar2_ff;

   always_ff @(posedge clock) begin
      s5_seg_ff <= s4_seg_ff;
      s5_a_ff   <= s4_a_ff;
      s5_h_ff   <= s4_h_ff;
      s5_cr2_ff <= (132'(s4_cc_hh_ff) << 64) + (132'(s4_cc_hl_ff) << 33) + 132'(s4_cc_ll_ff);
      s5_ar2_ff <= (132'(s4_ar_hh_ff) << 64)
                   + ((132'(s4_ar_hl_ff) + 132'(s4_ar_lh_ff)) << 32) + 132'(s4_ar_ll_ff);
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else begin
         s5_vld_ff <= s4_vld_ff;
      end
   end

   // stage 6: discriminant
   logic                 s6_vld_ff;
   pre_type              s6_pre_ff;
   logic [SQRT_IN_W-1:0] s6_disc_ff;
   logic [132:0]         s6_d_in;

   assign s6_d_in = {1'b0, s5_ar2_ff} - {1'b0, s5_cr2_ff};

   always_ff @(posedge clock) begin
      s6_pre_ff.seg  <= s5_seg_ff;
      s6_pre_ff.a    <= s5_a_ff;
      s6_pre_ff.h    <= s5_h_ff;
      s6_pre_ff.zero <= (s6_d_in == '0);
      s6_pre_ff.kill <= s6_d_in[132] | (s5_a_ff <= DEGEN_LIMIT);
      s6_disc_ff     <= s6_d_in[SQRT_IN_W-1:0];
      if (reset) begin
         s6_vld_ff <= 1'b0;
      end else begin
         s6_vld_ff <= s5_vld_ff;
      end
   end

   // square root with matching delay line
   logic                  sq_vld;
   logic [SQRT_OUT_W-1:0] sq_root;
   pre_type               sq_dly_ff [0:SQRT_OUT_W-1];

   sci_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s6_vld_ff),
      .in_value  (s6_disc_ff),
      .out_valid (sq_vld),
      .out_root  (sq_root)
   );

   always_ff @(posedge clock) begin
      sq_dly_ff[0] <= s6_pre_ff;
      for (int i = 1; i < SQRT_OUT_W; i++) begin
         sq_dly_ff[i] <= sq_dly_ff[i-1];
      end
   end

   // stage 7: root selection
   pre_type            s7_p;
   logic signed [67:0] s7_n1_in, s7_n2_in, s7_r1_in, s7_r2_in, s7_hx_in, s7_ax_in;
   logic               s7_v1_in, s7_v2_in;
   logic [1:0]         s7_count_in;
   logic               s7_vld_ff;
   post_type           s7_post_ff;
   logic [65:0]        s7_a_ff, s7_nf_ff, s7_ns_ff;

   always_comb begin
      s7_p     = sq_dly_ff[SQRT_OUT_W-1];
      s7_hx_in = {s7_p.h[66], s7_p.h};
      s7_ax_in = {2'b00, s7_p.a};
      s7_n1_in = 68'(sq_root) - s7_hx_in;
      s7_n2_in = -s7_hx_in - 68'(sq_root);
      s7_r1_in = s7_ax_in - s7_n1_in;
      s7_r2_in = s7_ax_in - s7_n2_in;
      s7_v1_in = ~s7_n1_in[67] & ~s7_r1_in[67];
      s7_v2_in = ~s7_n2_in[67] & ~s7_r2_in[67] & ~s7_p.zero;
      if (s7_p.kill) begin
         s7_count_in = 2'd0;
      end else if (s7_v1_in && s7_v2_in) begin
         s7_count_in = 2'd2;
      end else if (s7_v1_in || s7_v2_in) begin
         s7_count_in = 2'd1;
      end else begin
         s7_count_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      s7_post_ff.seg   <= s7_p.seg;
      s7_post_ff.count <= s7_count_in;
      s7_a_ff          <= s7_p.a;
      s7_nf_ff         <= s7_v1_in ? s7_n1_in[65:0] : s7_n2_in[65:0];
      s7_ns_ff         <= s7_n2_in[65:0];
      if (reset) begin
         s7_vld_ff <= 1'b0;
      end else begin
         s7_vld_ff <= sq_vld;
      end
   end

   // stage 8: n * |d| partial products, lanes first x, first y, second x, second y
   logic        s8_vld_ff;
   post_type    s8_post_ff;
   logic [65:0] s8_a_ff;
   logic [66:0] s8_hi_ff [0:3];
   logic [64:0] s8_lo_ff [0:3];
   logic [32:0] s8_mx_in, s8_my_in, s8_nx_in, s8_ny_in;
   logic [32:0] s8_m_in  [0:3];
   logic [65:0] s8_n_in  [0:3];

   always_comb begin
      s8_nx_in = -s7_post_ff.seg.dx;
      s8_ny_in = -s7_post_ff.seg.dy;
      s8_mx_in = s7_post_ff.seg.dx[32] ? s8_nx_in : s7_post_ff.seg.dx;
      s8_my_in = s7_post_ff.seg.dy[32] ? s8_ny_in : s7_post_ff.seg.dy;
      s8_m_in[0] = s8_mx_in;
      s8_m_in[1] = s8_my_in;
      s8_m_in[2] = s8_mx_in;
      s8_m_in[3] = s8_my_in;
      s8_n_in[0] = s7_nf_ff;
      s8_n_in[1] = s7_nf_ff;
      s8_n_in[2] = s7_ns_ff;
      s8_n_in[3] = s7_ns_ff;
   end

   always_ff @(posedge clock) begin
      s8_post_ff <= s7_post_ff;
      s8_a_ff    <= s7_a_ff;
      for (int i = 0; i < 4; i++) begin
         s8_hi_ff[i] <= 67'(s8_n_in[i][65:32]) * 67'(s8_m_in[i]);
         s8_lo_ff[i] <= 65'(s8_n_in[i][31:0]) * 65'(s8_m_in[i]);
      end
      if (reset) begin
         s8_vld_ff <= 1'b0;
      end else begin
         s8_vld_ff <= s7_vld_ff;
      end
   end

   // stage 9: rounding numerators
   logic                 s9_vld_ff;
   post_type             s9_post_ff;
   logic [DIV_NUM_W-1:0] s9_num_ff [0:3];
   logic [DIV_DEN_W-1:0] s9_den_ff;
   logic [98:0]          s9_prod_in [0:3];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         s9_prod_in[i] = (99'(s8_hi_ff[i]) << 32) + 99'(s8_lo_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      s9_post_ff <= s8_post_ff;
      s9_den_ff  <= {s8_a_ff, 1'b0};
      for (int i = 0; i < 4; i++) begin
         s9_num_ff[i] <= {1'b0, s9_prod_in[i], 1'b0} + DIV_NUM_W'(s8_a_ff);
      end
      if (reset) begin
         s9_vld_ff <= 1'b0;
      end else begin
         s9_vld_ff <= s8_vld_ff;
      end
   end

   // dividers with matching delay line
   logic                 dv_vld [0:3];
   logic [DIV_QUO_W-1:0] dv_quo [0:3];
   post_type             dv_dly_ff [0:DIV_QUO_W-1];

   for (genvar g = 0; g < 4; g++) begin : g_div
      sci_div u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (s9_vld_ff),
         .in_num    (s9_num_ff[g]),
         .in_den    (s9_den_ff),
         .out_valid (dv_vld[g]),
         .out_quo   (dv_quo[g])
      );
   end

   always_ff @(posedge clock) begin
      dv_dly_ff[0] <= s9_post_ff;
      for (int i = 1; i < DIV_QUO_W; i++) begin
         dv_dly_ff[i] <= dv_dly_ff[i-1];
      end
   end

   // stage 10: points and output register
   post_type           o_post;
   logic signed [31:0] o_pt_in [0:3];
   logic signed [34:0] o_sum;
   logic signed [31:0] o_s0;
   logic               o_neg;

   always_comb begin
      o_post = dv_dly_ff[DIV_QUO_W-1];
      for (int i = 0; i < 4; i++) begin
         o_s0  = i[0] ? o_post.seg.sy : o_post.seg.sx;
         o_neg = i[0] ? o_post.seg.dy[32] : o_post.seg.dx[32];
         if (o_neg) begin
            o_sum = {{3{o_s0[31]}}, o_s0} - {2'b00, dv_quo[i]};
         end else begin
            o_sum = {{3{o_s0[31]}}, o_s0} + {2'b00, dv_quo[i]};
         end
         if (o_sum > 35'sd2147483647) begin
            o_pt_in[i] = 32'sh7fffffff;
         end else if (o_sum < -35'sd2147483648) begin
            o_pt_in[i] = 32'sh80000000;
         end else begin
            o_pt_in[i] = o_sum[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit_count <= o_post.count;
      rsp_first_x   <= (o_post.count != 2'd0) ? o_pt_in[0] : '0;
      rsp_first_y   <= (o_post.count != 2'd0) ? o_pt_in[1] : '0;
      rsp_second_x  <= (o_post.count == 2'd2) ? o_pt_in[2] : '0;
      rsp_second_y  <= (o_post.count == 2'd2) ? o_pt_in[3] : '0;
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= dv_vld[0] & dv_vld[1] & dv_vld[2] & dv_vld[3];
      end
   end

   no_hit_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit_count == 2'd0 |-> rsp_first_x == 0 && rsp_first_y == 0
         && rsp_second_x == 0 && rsp_second_y == 0)
      else $error("no crossing but point not zero");

   one_hit_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit_count != 2'd2 |-> rsp_second_x == 0 && rsp_second_y == 0)
      else $error("second point set without two crossings");

   count_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hit_count != 2'd3)
      else $error("crossing count out of range");

   div_lanes_aligned : assert property (@(posedge clock) disable iff (reset)
      dv_vld[0] == dv_vld[1] && dv_vld[0] == dv_vld[2] && dv_vld[0] == dv_vld[3])
      else $error("divider lanes out of step");

endmodule

>>> test/segment_circle_intersection_unit_test.sv
// self-checking bench for segment_circle_intersection_unit: directed corners, then random
// segment / circle queries checked against an exact wide-integer predictor
// depends on sci_pkg and the segment_circle_intersection_unit rtl
module segment_circle_intersection_unit_test;
   import sci_pkg::*;

   typedef struct {
      logic signed [31:0] sx, sy, ex, ey, cx, cy;
      logic [30:0]        rad;
   } query_type;

   typedef struct {
      logic [1:0]         count;
      logic signed [31:0] x1, y1, x2, y2;
   } crossing_type;

   logic               clock = 0;
   logic               reset = 1;
   logic               start = 0;
   logic               busy;
   logic signed [31:0] req_start_x = 0, req_start_y = 0, req_end_x = 0, req_end_y = 0;
   logic signed [31:0] req_center_x = 0, req_center_y = 0;
   logic [30:0]        req_circle_radius = 0;
   logic               rsp_valid;
   logic [1:0]         rsp_hit_count;
   logic signed [31:0] rsp_first_x, rsp_first_y, rsp_second_x, rsp_second_y;

   crossing_type pending_crossings[$];
   int           error_count = 0;
   int           cycle_count = 0;
   int           idle_pct = 0;

   segment_circle_intersection_unit uut (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   function automatic logic signed [159:0] floor_root(logic signed [159:0] v);
      logic [159:0] r, c;
      r = 0;
      for (int b = 65; b >= 0; b--) begin
         c = r | (160'd1 << b);
         if (c * c <= v) r = c;
      end
      return r;
   endfunction

   function automatic logic signed [31:0] axis_point(logic signed [31:0] s0,
         logic signed [159:0] d, logic signed [159:0] n, logic signed [159:0] a);
      logic [159:0]       mag, num, q;
      logic signed [63:0] off, x;
      mag = d < 0 ? -d : d;
      num = 2 * (n * mag) + a;
      q   = num / (2 * a);
      off = {30'd0, q[33:0]};
      x   = s0 + (d < 0 ? -off : off);
      if (x > 64'sd2147483647) x = 64'sd2147483647;
      if (x < -64'sd2147483648) x = -64'sd2147483648;
      return x[31:0];
   endfunction

   function automatic crossing_type predict_crossings(query_type q);
      logic signed [159:0] dx, dy, px, py, r, a, h, c, disc, s, n1, n2, n;
      logic                v1, v2;
      crossing_type        o;
      o  = '{default: 0};
      dx = q.ex - q.sx;
      dy = q.ey - q.sy;
      px = q.sx - q.cx;
      py = q.sy - q.cy;
      r  = {129'd0, q.rad};
      a  = dx * dx + dy * dy;
      h  = dx * px + dy * py;
      c  = px * px + py * py - r * r;
      disc = h * h - a * c;
      if (a <= $signed({94'd0, DEGEN_LIMIT}) || disc < 0) return o;
      if (disc == 0) begin
         if (-h >= 0 && a + h >= 0) begin
            o.count = 1;
            o.x1 = axis_point(q.sx, dx, -h, a);
            o.y1 = axis_point(q.sy, dy, -h, a);
         end
         return o;
      end
      s  = floor_root(disc);
      n1 = s - h;
      n2 = -h - s;
      v1 = n1 >= 0 && n1 <= a;
      v2 = n2 >= 0 && n2 <= a;
      if (v1 && v2) begin
         o.count = 2;
         o.x1 = axis_point(q.sx, dx, n1, a);
         o.y1 = axis_point(q.sy, dy, n1, a);
         o.x2 = axis_point(q.sx, dx, n2, a);
         o.y2 = axis_point(q.sy, dy, n2, a);
      end else if (v1 || v2) begin
         n = v1 ? n1 : n2;
         o.count = 1;
         o.x1 = axis_point(q.sx, dx, n, a);
         o.y1 = axis_point(q.sy, dy, n, a);
      end
      return o;
   endfunction

   task automatic report_mismatch(string field, logic signed [31:0] got,
         logic signed [31:0] want);
      $display("mismatch %s: got %0d expected %0d", field, got, want);
      error_count++;
   endtask

   // scoreboard: capture transfers and compare results in order
   always @(posedge clock) begin
      query_type    q;
      crossing_type e;
      cycle_count++;
      if (cycle_count > 200000) begin
         $display("FAIL segment_circle_intersection_unit");
         $finish;
      end
      if (!reset && start && !busy) begin
         q = '{req_start_x, req_start_y, req_end_x, req_end_y,
               req_center_x, req_center_y, req_circle_radius};
         pending_crossings.push_back(predict_crossings(q));
      end
      if (!reset && rsp_valid) begin
         if (pending_crossings.size() == 0) begin
            $display("unexpected result");
            error_count++;
         end else begin
            e = pending_crossings.pop_front();
            if (rsp_hit_count != e.count) report_mismatch("hit_count", rsp_hit_count, e.count);
            if (rsp_first_x != e.x1) report_mismatch("first_x", rsp_first_x, e.x1);
            if (rsp_first_y != e.y1) report_mismatch("first_y", rsp_first_y, e.y1);
            if (rsp_second_x != e.x2) report_mismatch("second_x", rsp_second_x, e.x2);
            if (rsp_second_y != e.y2) report_mismatch("second_y", rsp_second_y, e.y2);
         end
      end
   end

   task automatic send_query(query_type q);
      logic ok;
      while ($urandom_range(99) < idle_pct) begin
         start <= 0;
         @(posedge clock);
      end
      start             <= 1;
      req_start_x       <= q.sx;
      req_start_y       <= q.sy;
      req_end_x         <= q.ex;
      req_end_y         <= q.ey;
      req_center_x      <= q.cx;
      req_center_y      <= q.cy;
      req_circle_radius <= q.rad;
      do begin
         @(negedge clock);
         ok = !busy;
         @(posedge clock);
      end while (!ok);
   endtask

   function automatic logic signed [31:0] near(logic signed [31:0] base, int span);
      logic signed [63:0] v;
      v = base + $signed($urandom_range(2 * span)) - span;
      return v[31:0];
   endfunction

   function automatic query_type random_query();
      query_type q;
      int        span;
      q.cx  = $urandom;
      q.cy  = $urandom;
      q.sx  = $urandom;
      q.sy  = $urandom;
      q.ex  = $urandom;
      q.ey  = $urandom;
      q.rad = 31'($urandom);
      if ($urandom_range(99) < 80) begin
         q.cx  = near(0, 1 << 28);
         q.cy  = near(0, 1 << 28);
         q.rad = 31'($urandom_range(1 << ($urandom_range(26, 4))));
         span  = 2 * q.rad + 16;
         q.sx  = near(q.cx, span);
         q.sy  = near(q.cy, span);
         q.ex  = near(q.cx, span);
         q.ey  = near(q.cy, span);
      end
      return q;
   endfunction

   task automatic test_directed();
      query_type q;
      idle_pct = 0;
      send_query('{0, 0, 0, 0, 0, 0, 31'd65536});                       // degenerate, zero length
      send_query('{0, 0, 6, 2, 0, 0, 31'd1});                           // degenerate, tiny length
      send_query('{0, 0, 6, 3, 0, 0, 31'd3});                           // just above the limit
      send_query('{-32'sd200000, 65536, 200000, 65536, 0, 0, 31'd65536}); // tangent
      send_query('{-32'sd200000, 0, 200000, 0, 0, 0, 31'd65536});       // two crossings
      send_query('{0, 0, 200000, 0, 0, 0, 31'd65536});                  // one crossing
      send_query('{0, 0, 1000, 0, 0, 0, 31'd65536});                    // inside, none
      send_query('{-32'sd200000, 300000, 200000, 300000, 0, 0, 31'd65536}); // miss
      send_query('{200000, 0, 900000, 0, 0, 0, 31'd65536});             // roots behind segment
      send_query('{32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
                   0, 0, 31'h7fffffff});
      send_query('{32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
                   32'sh7fffffff, 32'sh80000000, 31'h7fffffff});
      send_query('{32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                   32'sh80000000, 32'sh7fffffff, 31'h7fffffff});
      send_query('{32'sh7fffffff, 0, 32'sh80000000, 0, 0, 0, 31'h7fffffff});
      send_query('{0, 32'sh80000000, 0, 32'sh7fffffff, 0, 0, 31'd0});
      send_query('{-1, -1, -1, -1, -1, -1, 31'h7fffffff});
      q = '{5, 7, 5 + 65536, 7, 5, 7, 31'd0};                            // zero radius at start
      send_query(q);
   endtask

   task automatic test_random_stream(int n, int pct);
      idle_pct = pct;
      repeat (n) send_query(random_query());
   endtask

   task automatic test_drain_pause();
      idle_pct = 0;
      start <= 0;
      @(posedge clock);
      while (pending_crossings.size() != 0) @(posedge clock);
      test_random_stream(50, 27);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_random_stream(700, 27);
      test_random_stream(400, 0);
      test_drain_pause();
      test_random_stream(750, 27);
      start <= 0;
      while (pending_crossings.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
      if (error_count == 0)
         $display("PASS segment_circle_intersection_unit");
      else
         $display("FAIL segment_circle_intersection_unit");
      $finish;
   end
endmodule
